// ----- rtl/cle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int LEN_W = 6;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [7:0]       char_t;
  typedef logic [1:0]       kind_t;
  typedef logic [2:0]       status_t;

  // result kinds
  localparam kind_t K_ECHO  = 2'd0;
  localparam kind_t K_ERASE = 2'd1;
  localparam kind_t K_LINE  = 2'd2;
  localparam kind_t K_END   = 2'd3;

  // end status codes
  localparam status_t ST_NONE    = 3'd0;
  localparam status_t ST_NEWLINE = 3'd1;
  localparam status_t ST_LIMIT   = 3'd2;
  localparam status_t ST_CTRL_D  = 3'd3;
  localparam status_t ST_EOF     = 3'd4;
  localparam status_t ST_CANCEL  = 3'd5;

  // character codes
  localparam char_t CH_BS    = 8'h08;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_ETX   = 8'h03;
  localparam char_t CH_EOT   = 8'h04;
  localparam char_t CH_NAK   = 8'h15;
  localparam char_t CH_DEL   = 8'h7F;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_CARET = 8'h5E;
  localparam char_t CH_UC_C  = 8'h43;

  // register map
  localparam len_t LIMIT_RST = 6'd63;

endpackage

`default_nettype wire

// ----- rtl/canonical_line_editor_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Canonical line editor. Received characters enter on the in_valid/in_ready
// channel, one transaction per character. Results leave on out_valid/out_ready:
// echoes, erase counts and, when a line ends, the stored line byte by byte with
// the end status on its final byte (one line-end item if empty or cancelled).
// last marks the final result caused by one character.
// An APB write with paddr[2] low sets line_limit; a read there returns it.
// After acceptance the editor enters a state that loads the first result into
// the output register; Ctrl+D on a non-empty line first passes through S_READ,
// which starts a memory read. Echoes, erases and line-end items are each loaded
// from their own state; each line byte passes through S_READ, which reads the
// character memory, and S_BYTE, which loads the output register. An ignored
// character is accepted in S_IDLE. The editor works on one character at a time.
// The output register lets a new character be accepted while the final result
// of the previous one still waits. When the receiver stalls, the sequence holds
// in place. Reset empties the line, sets line_limit to 63 and clears out_valid;
// the character memory itself is not cleared (only written entries are read).

module canonical_line_editor_top #(
  parameter int MAX_LINE = 63
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cle_pkg::char_t  rx_char,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cle_pkg::kind_t       kind,
  output cle_pkg::char_t       out_byte,
  output cle_pkg::len_t        amount,
  output cle_pkg::status_t     end_status,
  output logic                 last,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import cle_pkg::*;

  localparam int   AW      = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam len_t MAX_LEN = len_t'(MAX_LINE);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ECHO   = 3'd1;
  localparam logic [2:0] S_ERASE  = 3'd2;
  localparam logic [2:0] S_CANCEL = 3'd3;
  localparam logic [2:0] S_EMPTY  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_BYTE   = 3'd6;

  logic [2:0]  state, state_next;
  len_t        length, length_next;
  len_t        line_limit;
  len_t        lim_eff;
  char_t       echo_byte, echo_byte_next;
  logic        do_emit, do_emit_next;
  status_t     emit_status, emit_status_next;
  len_t        erase_amt, erase_amt_next;
  len_t        emit_n, emit_n_next;
  logic [AW-1:0] idx, idx_next;
  logic [1:0]  cnt, cnt_next;
  len_t        len_new;
  logic        fin;

  logic        slot_free;
  logic        push;
  kind_t       p_kind;
  char_t       p_byte;
  len_t        p_amount;
  status_t     p_status;
  logic        p_last;

  logic        ram_we;
  logic        ram_re;
  char_t       ram_rdata;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, line_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      line_limit <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    if (line_limit == '0) begin
      lim_eff = len_t'(1);
    end else if (line_limit > MAX_LEN) begin
      lim_eff = MAX_LEN;
    end else begin
      lim_eff = line_limit;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign len_new   = (length < MAX_LEN) ? length + len_t'(1) : length;
  assign fin       = (len_t'(idx) == emit_n - len_t'(1));

  always_comb begin
    state_next       = state;
    length_next      = length;
    echo_byte_next   = echo_byte;
    do_emit_next     = do_emit;
    emit_status_next = emit_status;
    erase_amt_next   = erase_amt;
    emit_n_next      = emit_n;
    idx_next         = idx;
    cnt_next         = cnt;
    push             = 1'b0;
    p_kind           = K_ECHO;
    p_byte           = '0;
    p_amount         = '0;
    p_status         = ST_NONE;
    p_last           = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (rx_char == CH_LF || rx_char == CH_CR) begin
            echo_byte_next   = CH_LF;
            do_emit_next     = 1'b1;
            emit_status_next = ST_NEWLINE;
            state_next       = S_ECHO;
          end else if (rx_char == CH_BS || rx_char == CH_DEL) begin
            if (length != '0) begin
              length_next    = length - len_t'(1);
              erase_amt_next = len_t'(1);
              state_next     = S_ERASE;
            end
          end else if (rx_char == CH_ETX) begin
            length_next = '0;
            cnt_next    = '0;
            state_next  = S_CANCEL;
          end else if (rx_char == CH_EOT) begin
            emit_status_next = (length != '0) ? ST_CTRL_D : ST_EOF;
            emit_n_next      = length;
            length_next      = '0;
            idx_next         = '0;
            state_next       = (length == '0) ? S_EMPTY : S_READ;
          end else if (rx_char == CH_NAK) begin
            if (length != '0) begin
              erase_amt_next = length;
              length_next    = '0;
              state_next     = S_ERASE;
            end
          end else if (rx_char >= CH_SPACE && rx_char < CH_DEL) begin
            ram_we           = (length < MAX_LEN);
            length_next      = len_new;
            echo_byte_next   = rx_char;
            do_emit_next     = (len_new >= lim_eff);
            emit_status_next = ST_LIMIT;
            state_next       = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          push   = 1'b1;
          p_kind = K_ECHO;
          p_byte = echo_byte;
          p_last = !do_emit;
          if (do_emit) begin
            emit_n_next = length;
            length_next = '0;
            idx_next    = '0;
            state_next  = (length == '0) ? S_EMPTY : S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_ERASE: begin
        if (slot_free) begin
          push       = 1'b1;
          p_kind     = K_ERASE;
          p_amount   = erase_amt;
          p_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CANCEL: begin
        if (slot_free) begin
          push     = 1'b1;
          cnt_next = cnt + 2'd1;
          case (cnt)
            2'd0: p_byte = CH_CARET;
            2'd1: p_byte = CH_UC_C;
            2'd2: p_byte = CH_LF;
            default: begin
              p_kind     = K_END;
              p_status   = ST_CANCEL;
              p_last     = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          push       = 1'b1;
          p_kind     = K_END;
          p_status   = emit_status;
          p_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_BYTE;
      end
      S_BYTE: begin
        if (slot_free) begin
          push     = 1'b1;
          p_kind   = K_LINE;
          p_byte   = ram_rdata;
          p_amount = emit_n;
          p_status = fin ? emit_status : ST_NONE;
          p_last   = fin;
          if (fin) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    echo_byte   <= echo_byte_next;
    do_emit     <= do_emit_next;
    emit_status <= emit_status_next;
    erase_amt   <= erase_amt_next;
    emit_n      <= emit_n_next;
    idx         <= idx_next;
    cnt         <= cnt_next;
    if (push) begin
      kind       <= p_kind;
      out_byte   <= p_byte;
      amount     <= p_amount;
      end_status <= p_status;
      last       <= p_last;
    end
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (length[AW-1:0]),
    .wdata (rx_char),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= MAX_LEN)
    else $error("line length above store depth");

  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_BYTE) |-> (len_t'(idx) < emit_n))
    else $error("line readout beyond finished line");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_status != ST_NONE) |-> last)
    else $error("end status on a result that is not the last");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ECHO && !slot_free) |=> (state == S_ECHO && !in_ready))
    else $error("echo dropped while output stalled");

endmodule

`default_nettype wire

// ----- rtl/cle_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
